// ----- design/vds_pkg.sv -----
// Shared types, constants and the direction table for the velocity direction snap unit.
// No dependencies; every other design file imports this package.
package vds_pkg;

    // Number of evenly spaced directions, starting at angle zero, counter-clockwise.
    localparam int NUM_DIRECTIONS = 6;
    localparam int DIR_MAX        = 64;
    localparam int DIR_COUNT      = (NUM_DIRECTIONS < 1) ? 1 :
                                    ((NUM_DIRECTIONS > DIR_MAX) ? DIR_MAX : NUM_DIRECTIONS);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // Taylor series divisors for the sine and cosine terms.
    localparam longint unsigned SIN_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210};
    localparam longint unsigned COS_DIV [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                  64'd90, 64'd132, 64'd182};

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } dir_vec_t;

    typedef dir_vec_t [DIR_MAX-1:0] dir_table_t;

    // One item moving along the row of direction cells.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [5:0]         best_idx;
        logic signed [32:0] best_dp;
    } dir_item_t;

    // One item moving along the row of square root cells.
    typedef struct packed {
        logic        valid;
        logic [31:0] rem;
        logic [31:0] root;
        logic [5:0]  idx;
        logic [14:0] ax;
        logic [14:0] ay;
        logic        nx;
        logic        ny;
    } sqrt_item_t;

    // Clamp a Q2.30 value to [0, 1] and round it to Q1.14.
    function automatic logic signed [15:0] q30_to_q14(longint v);
        longint w;
        w = v;
        if (w < 0)
        begin
            w = 0;
        end
        if (w > ONE_Q30)
        begin
            w = ONE_Q30;
        end
        return 16'((w + 64'sd32768) >>> 16);
    endfunction

    // Unit vector of direction i, built with a truncating Taylor series.
    function automatic dir_vec_t dir_entry(int unsigned i);
        longint unsigned phase;
        longint unsigned r;
        longint unsigned x;
        longint unsigned t;
        longint          ssum;
        longint          csum;
        logic [1:0]      q;
        logic signed [15:0] c;
        logic signed [15:0] s;
        dir_vec_t        e;
        int              k;
        phase = (64'(i) << 32) / DIR_COUNT;
        q     = phase[31:30];
        r     = {34'd0, phase[29:0]};
        x     = (r * HALF_PI_Q30) >> 30;
        t     = x;
        ssum  = longint'(x);
        for (k = 1; k <= 7; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / SIN_DIV[k];
            if ((k % 2) == 1)
            begin
                ssum = ssum - longint'(t);
            end
            else
            begin
                ssum = ssum + longint'(t);
            end
        end
        t    = 64'd1073741824;
        csum = ONE_Q30;
        for (k = 1; k <= 7; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / COS_DIV[k];
            if ((k % 2) == 1)
            begin
                csum = csum - longint'(t);
            end
            else
            begin
                csum = csum + longint'(t);
            end
        end
        c = q30_to_q14(csum);
        s = q30_to_q14(ssum);
        case (q)
            2'd0:
            begin
                e.cx = c;
                e.cy = s;
            end
            2'd1:
            begin
                e.cx = -s;
                e.cy = c;
            end
            2'd2:
            begin
                e.cx = -c;
                e.cy = -s;
            end
            default:
            begin
                e.cx = s;
                e.cy = -c;
            end
        endcase
        return e;
    endfunction

    function automatic dir_table_t build_dir_table();
        dir_table_t tab;
        int         i;
        tab = '0;
        for (i = 0; i < DIR_COUNT; i++)
        begin
            tab[i] = dir_entry(i);
        end
        return tab;
    endfunction

    // Direction unit vectors in Q1.14; entries past the direction count are zero.
    localparam dir_table_t DIR_TABLE = build_dir_table();

endpackage

// ----- design/vds_dir_cell.sv -----
// One cell of the direction row: dot product of the item with one direction, then a
// compare against the running best. Depends on vds_pkg.
module vds_dir_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [5:0]         cell_index,
    input  vds_pkg::dir_item_t item_in,
    output vds_pkg::dir_item_t item_out
);
    import vds_pkg::*;

    dir_vec_t           dir;
    logic               a_valid_reg;
    dir_item_t          a_item_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] px_next;
    logic signed [31:0] py_next;
    logic signed [32:0] dp;
    logic               take;
    logic               b_valid_reg;
    dir_item_t          b_item_reg;
    dir_item_t          b_item_next;

    assign dir     = DIR_TABLE[cell_index];
    assign px_next = item_in.vx * dir.cx;
    assign py_next = item_in.vy * dir.cy;

    // The first cell always takes its direction, later cells only on a strictly larger score.
    always_comb
    begin
        dp          = {px_reg[31], px_reg} + {py_reg[31], py_reg};
        take        = (cell_index == 6'd0) || (dp > a_item_reg.best_dp);
        b_item_next = a_item_reg;
        if (take)
        begin
            b_item_next.best_idx = cell_index;
            b_item_next.best_dp  = dp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= item_in.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= item_in;
            px_reg     <= px_next;
            py_reg     <= py_next;
            b_item_reg <= b_item_next;
        end
    end

    always_comb
    begin
        item_out       = b_item_reg;
        item_out.valid = b_valid_reg;
    end

endmodule

// ----- design/vds_sqrt_cell.sv -----
// One cell of the square root row: settles one result bit per cell, restoring method.
// Depends on vds_pkg.
module vds_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic [3:0]          step,
    input  vds_pkg::sqrt_item_t item_in,
    output vds_pkg::sqrt_item_t item_out
);
    import vds_pkg::*;

    logic [31:0] bit_val;
    logic [31:0] trial;
    sqrt_item_t  item_next;
    sqrt_item_t  item_reg;
    logic        valid_reg;

    // Step zero works on the bit of weight 4^15, the last step on weight 1.
    assign bit_val = 32'd1 << {~step, 1'b0};
    assign trial   = item_in.root + bit_val;

    always_comb
    begin
        item_next = item_in;
        if (item_in.rem >= trial)
        begin
            item_next.rem  = item_in.rem - trial;
            item_next.root = (item_in.root >> 1) + bit_val;
        end
        else
        begin
            item_next.root = item_in.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    always_comb
    begin
        item_out       = item_reg;
        item_out.valid = valid_reg;
    end

endmodule

// ----- design/velocity_direction_snap_unit.sv -----
// Top level of the velocity direction snap unit: direction row, square root row and
// the final scale stage. Depends on vds_pkg, vds_dir_cell and vds_sqrt_cell.
//
// Usage:
//   Each item on the slave stream carries one Q8.8 velocity sample. The block snaps it
//   to the nearest of NUM_DIRECTIONS evenly spaced unit directions (best dot product,
//   lowest index on a tie) and returns that direction scaled by the sample's magnitude,
//   each component saturated to 16 bits, together with the direction index.
//   A zero sample gives index zero and a zero result.
//   From acceptance to m_tvalid an item passes two registers in each direction cell,
//   the squares register, the sum register, sixteen square root cells, the scaling
//   multiply register and the output register.
//   Throughput is one item per cycle when not stalled; every cell hands its item on at each advance.
//   The whole row moves together: when the output register holds an item that the
//   receiver does not take, every stage stalls and s_tready drops in the same cycle.
//   While the output register is empty or being emptied, a new item enters each cycle.
//   Reset clears all valid bits; the direction table is a constant and needs no setup.
module velocity_direction_snap_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // velocity_x [15:0], velocity_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // snapped_x [15:0], snapped_y [31:16],
                                   // direction_index [37:32], zero [39:38]
);
    import vds_pkg::*;

    logic        adv;
    dir_item_t   dir_link [DIR_COUNT+1];
    dir_item_t   dir_last;
    sqrt_item_t  sqrt_link [17];

    // Square stage.
    logic        sq_valid_reg;
    logic [31:0] sq_x_reg;
    logic [31:0] sq_y_reg;
    logic [31:0] sq_x_next;
    logic [31:0] sq_y_next;
    logic [5:0]  sq_idx_reg;
    logic [14:0] sq_ax_reg;
    logic [14:0] sq_ay_reg;
    logic [14:0] sq_ax_next;
    logic [14:0] sq_ay_next;
    logic        sq_nx_reg;
    logic        sq_ny_reg;
    dir_vec_t    best_dir;
    logic signed [15:0] neg_cx;
    logic signed [15:0] neg_cy;

    // Sum stage, which feeds the square root row.
    logic        sum_valid_reg;
    sqrt_item_t  sum_item_reg;
    sqrt_item_t  sum_item_next;

    // Scale stage.
    logic        mul_valid_reg;
    logic [30:0] mul_x_reg;
    logic [30:0] mul_y_reg;
    logic        mul_nx_reg;
    logic        mul_ny_reg;
    logic [5:0]  mul_idx_reg;
    logic [15:0] mag;

    // Output register.
    logic        m_valid_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [5:0]  out_idx_reg;
    logic [15:0] out_x_next;
    logic [15:0] out_y_next;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Direction row.
    always_comb
    begin
        dir_link[0].valid    = s_tvalid;
        dir_link[0].vx       = s_tdata[15:0];
        dir_link[0].vy       = s_tdata[31:16];
        dir_link[0].best_idx = 6'd0;
        dir_link[0].best_dp  = '0;
    end

    for (genvar i = 0; i < DIR_COUNT; i++)
    begin : g_dir
        vds_dir_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (6'(i)),
            .item_in    (dir_link[i]),
            .item_out   (dir_link[i+1])
        );
    end

    assign dir_last = dir_link[DIR_COUNT];

    // Squares of the components, and magnitude and sign of the winning direction.
    always_comb
    begin
        sq_x_next  = 32'(dir_last.vx * dir_last.vx);
        sq_y_next  = 32'(dir_last.vy * dir_last.vy);
        best_dir   = DIR_TABLE[dir_last.best_idx];
        neg_cx     = -best_dir.cx;
        neg_cy     = -best_dir.cy;
        sq_ax_next = best_dir.cx[15] ? neg_cx[14:0] : best_dir.cx[14:0];
        sq_ay_next = best_dir.cy[15] ? neg_cy[14:0] : best_dir.cy[14:0];
    end

    always_comb
    begin
        sum_item_next.valid = sq_valid_reg;
        sum_item_next.rem   = sq_x_reg + sq_y_reg;
        sum_item_next.root  = '0;
        sum_item_next.idx   = sq_idx_reg;
        sum_item_next.ax    = sq_ax_reg;
        sum_item_next.ay    = sq_ay_reg;
        sum_item_next.nx    = sq_nx_reg;
        sum_item_next.ny    = sq_ny_reg;
    end

    always_comb
    begin
        sqrt_link[0]       = sum_item_reg;
        sqrt_link[0].valid = sum_valid_reg;
    end

    // Square root row; the radicand is at most 2^31, so sixteen steps cover it.
    for (genvar j = 0; j < 16; j++)
    begin : g_sqrt
        vds_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .step     (4'(j)),
            .item_in  (sqrt_link[j]),
            .item_out (sqrt_link[j+1])
        );
    end

    assign mag = sqrt_link[16].root[15:0];

    // Round the Q8.8 times Q1.14 magnitude to nearest, ties away from zero, then
    // saturate with the direction's sign.
    function automatic logic [15:0] round_sat(logic [30:0] prod, logic neg);
        logic [30:0] rounded;
        logic [16:0] q_mag;
        logic [15:0] res;
        rounded = prod + 31'd8192;
        q_mag   = rounded[30:14];
        if (!neg)
        begin
            res = (q_mag > 17'd32767) ? 16'h7FFF : q_mag[15:0];
        end
        else
        begin
            res = (q_mag > 17'd32768) ? 16'h8000 : 16'(-q_mag);
        end
        return res;
    endfunction

    assign out_x_next = round_sat(mul_x_reg, mul_nx_reg);
    assign out_y_next = round_sat(mul_y_reg, mul_ny_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg  <= dir_last.valid;
            sum_valid_reg <= sq_valid_reg;
            mul_valid_reg <= sqrt_link[16].valid;
            m_valid_reg   <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_x_reg     <= sq_x_next;
            sq_y_reg     <= sq_y_next;
            sq_idx_reg   <= dir_last.best_idx;
            sq_ax_reg    <= sq_ax_next;
            sq_ay_reg    <= sq_ay_next;
            sq_nx_reg    <= best_dir.cx[15];
            sq_ny_reg    <= best_dir.cy[15];
            sum_item_reg <= sum_item_next;
            mul_x_reg    <= 31'(mag) * 31'(sqrt_link[16].ax);
            mul_y_reg    <= 31'(mag) * 31'(sqrt_link[16].ay);
            mul_nx_reg   <= sqrt_link[16].nx;
            mul_ny_reg   <= sqrt_link[16].ny;
            mul_idx_reg  <= sqrt_link[16].idx;
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_idx_reg  <= mul_idx_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_idx_reg, out_y_reg, out_x_reg};

endmodule
